// ===== design/sahl_pkg.sv =====
// ----------------------------------------------------------------------------
// sahl_pkg
// Shared types, sizes and codes for the sensor average and history logger.
// ----------------------------------------------------------------------------
package sahl_pkg;

  // Sizing of the windows, accumulators and history ring.
  localparam int HIST_DEPTH = 16;
  localparam int WINDOW_LEN = 5;
  localparam int ACC_MAX    = 255;

  // Field widths of the request and result items.
  localparam int REQ_W   = 2;
  localparam int LIGHT_W = 7;
  localparam int TEMP_W  = 12;
  localparam int POS_W   = 4;

  // Derived widths.
  localparam int WIN_IDX_W  = $clog2(WINDOW_LEN);
  localparam int LSUM_W     = LIGHT_W + WIN_IDX_W;
  localparam int TSUM_W     = TEMP_W + WIN_IDX_W;
  localparam int CNT_W      = $clog2(ACC_MAX + 1);
  localparam int LACC_W     = LIGHT_W + CNT_W;
  localparam int TACC_W     = TEMP_W + CNT_W;
  localparam int DIV_W      = TACC_W;
  localparam int DCNT_W     = $clog2(DIV_W);
  localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
  localparam int HCNT_W     = $clog2(HIST_DEPTH + 1);
  localparam int CMP_W      = (HCNT_W > POS_W) ? HCNT_W : POS_W;
  localparam int ENTRY_W    = LIGHT_W + TEMP_W;

  // Division by the window length: multiply by a rounded-up reciprocal.
  localparam int                 RECIP_SH = 20;
  localparam logic [RECIP_SH-1:0] RECIP   =
    RECIP_SH'(((2 ** RECIP_SH) + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam int LPROD_W = LSUM_W + RECIP_SH;
  localparam int TPROD_W = TSUM_W + RECIP_SH;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // One request item.
  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [LIGHT_W-1:0]        light_in;
    logic signed [TEMP_W-1:0]  temp_in;
    logic [POS_W-1:0]          read_pos;
  } in_t;

  // One result item.
  typedef struct packed {
    logic [LIGHT_W-1:0]        light_level;
    logic signed [TEMP_W-1:0]  temp_value;
    logic [HCNT_W-1:0]         entry_count;
    logic                      stored;
    logic                      valid_res;
  } out_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WIN,
    ST_SUM,
    ST_SCALE,
    ST_ACC,
    ST_DIV_LD,
    ST_DIV,
    ST_COMMIT,
    ST_RD,
    ST_RD_DATA,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_ld;
    logic win_wr;
    logic sum_ld;
    logic avg_ld;
    logic acc_add;
    logic div_ld;
    logic div_step;
    logic commit;
    logic rd_ld;
    logic out_ld;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             acc_zero;
    logic             read_ok;
    logic             div_last;
    logic             out_free;
  } sts_t;

endpackage

// ===== design/sahl_ram.sv =====
// ----------------------------------------------------------------------------
// sahl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sahl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/sahl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sahl_ctrl
// Controller: sequences sample, commit and read requests through the datapath.
// ----------------------------------------------------------------------------
module sahl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sahl_pkg::sts_t sts,
  output sahl_pkg::cmd_t cmd
);

  sahl_pkg::state_t state_r;
  sahl_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sahl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sahl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sahl_pkg::ST_DECODE;
        end
      end
      sahl_pkg::ST_DECODE: begin
        unique case (sts.req)
          sahl_pkg::REQ_SAMPLE: state_nxt = sahl_pkg::ST_WIN;
          sahl_pkg::REQ_COMMIT: begin
            state_nxt = sts.acc_zero ? sahl_pkg::ST_OUT : sahl_pkg::ST_DIV_LD;
          end
          sahl_pkg::REQ_READ: begin
            state_nxt = sts.read_ok ? sahl_pkg::ST_RD : sahl_pkg::ST_OUT;
          end
          default: state_nxt = sahl_pkg::ST_OUT;
        endcase
      end
      sahl_pkg::ST_WIN:    state_nxt = sahl_pkg::ST_SUM;
      sahl_pkg::ST_SUM:    state_nxt = sahl_pkg::ST_SCALE;
      sahl_pkg::ST_SCALE:  state_nxt = sahl_pkg::ST_ACC;
      sahl_pkg::ST_ACC:    state_nxt = sahl_pkg::ST_OUT;
      sahl_pkg::ST_DIV_LD: state_nxt = sahl_pkg::ST_DIV;
      sahl_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = sahl_pkg::ST_COMMIT;
        end
      end
      sahl_pkg::ST_COMMIT:  state_nxt = sahl_pkg::ST_OUT;
      sahl_pkg::ST_RD:      state_nxt = sahl_pkg::ST_RD_DATA;
      sahl_pkg::ST_RD_DATA: state_nxt = sahl_pkg::ST_OUT;
      sahl_pkg::ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = sahl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sahl_pkg::ST_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != sahl_pkg::ST_IDLE);
    unique case (state_r)
      sahl_pkg::ST_IDLE:    cmd.item_ld  = in_valid;
      sahl_pkg::ST_WIN:     cmd.win_wr   = 1'b1;
      sahl_pkg::ST_SUM:     cmd.sum_ld   = 1'b1;
      sahl_pkg::ST_SCALE:   cmd.avg_ld   = 1'b1;
      sahl_pkg::ST_ACC:     cmd.acc_add  = 1'b1;
      sahl_pkg::ST_DIV_LD:  cmd.div_ld   = 1'b1;
      sahl_pkg::ST_DIV:     cmd.div_step = 1'b1;
      sahl_pkg::ST_COMMIT:  cmd.commit   = 1'b1;
      sahl_pkg::ST_RD_DATA: cmd.rd_ld    = 1'b1;
      sahl_pkg::ST_OUT:     cmd.out_ld   = sts.out_free;
      default:              cmd          = '0;
    endcase
  end

endmodule

// ===== design/sahl_dp.sv =====
// ----------------------------------------------------------------------------
// sahl_dp
// Datapath: averaging windows, period accumulators, serial dividers,
// history ring and the result register.
// ----------------------------------------------------------------------------
module sahl_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  sahl_pkg::in_t  in_data,
  output sahl_pkg::out_t out_data,
  output logic           out_valid,
  input  logic           out_stall,
  input  sahl_pkg::cmd_t cmd,
  output sahl_pkg::sts_t sts
);

  // Latched request.
  sahl_pkg::in_t item_r;

  // Averaging windows.
  logic [sahl_pkg::LIGHT_W-1:0]       light_win_r [sahl_pkg::WINDOW_LEN];
  logic signed [sahl_pkg::TEMP_W-1:0] temp_win_r  [sahl_pkg::WINDOW_LEN];
  logic [sahl_pkg::WIN_IDX_W-1:0]     win_pos_r;
  logic [sahl_pkg::WIN_IDX_W-1:0]     win_pos_nxt;

  // Window sums.
  logic [sahl_pkg::LSUM_W-1:0]        lsum;
  logic signed [sahl_pkg::TSUM_W-1:0] tsum;
  logic [sahl_pkg::LSUM_W-1:0]        lsum_r;
  logic [sahl_pkg::TSUM_W-1:0]        tmag_r;
  logic                               tneg_r;

  // Scaling by the reciprocal of the window length.
  logic [sahl_pkg::LPROD_W-1:0] lprod;
  logic [sahl_pkg::TPROD_W-1:0] tprod;
  logic [sahl_pkg::TEMP_W-1:0]  tavg_mag;

  // Period accumulators.
  logic [sahl_pkg::LACC_W-1:0]        light_acc_r;
  logic signed [sahl_pkg::TACC_W-1:0] temp_acc_r;
  logic [sahl_pkg::CNT_W-1:0]         acc_cnt_r;

  // Serial dividers, one lane per channel, sharing the step counter.
  logic [sahl_pkg::DIV_W-1:0]  ldvd_r;
  logic [sahl_pkg::DIV_W-1:0]  tdvd_r;
  logic [sahl_pkg::CNT_W-1:0]  lrem_r;
  logic [sahl_pkg::CNT_W-1:0]  trem_r;
  logic                        dneg_r;
  logic [sahl_pkg::DCNT_W-1:0] dcnt_r;
  logic [sahl_pkg::CNT_W:0]    ltrial;
  logic [sahl_pkg::CNT_W:0]    ttrial;
  logic [sahl_pkg::CNT_W:0]    dvsr;
  logic                        lge;
  logic                        tge;
  logic [sahl_pkg::CNT_W-1:0]  lrem_nxt;
  logic [sahl_pkg::CNT_W-1:0]  trem_nxt;
  logic [sahl_pkg::TEMP_W-1:0] tq;
  logic [sahl_pkg::TEMP_W-1:0] tmean;
  logic [sahl_pkg::DIV_W-1:0]  tacc_mag;

  // History ring.
  logic [sahl_pkg::HIST_IDX_W-1:0] wptr_r;
  logic [sahl_pkg::HIST_IDX_W-1:0] wptr_nxt;
  logic [sahl_pkg::HCNT_W-1:0]     hcnt_r;
  logic [sahl_pkg::HIST_IDX_W-1:0] rd_start;
  logic [sahl_pkg::HIST_IDX_W:0]   rd_sum;
  logic [sahl_pkg::HIST_IDX_W-1:0] rd_idx;
  logic [sahl_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [sahl_pkg::ENTRY_W-1:0]    ram_rdata;

  // Result under construction and output register.
  logic [sahl_pkg::LIGHT_W-1:0] res_light_r;
  logic [sahl_pkg::TEMP_W-1:0]  res_temp_r;
  logic                         res_stored_r;
  logic                         res_valid_r;
  sahl_pkg::out_t               out_data_r;
  logic                         out_valid_r;
  logic                         out_free;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_r <= in_data;
    end
  end

  // Window write pointer wraps at the window length.
  assign win_pos_nxt = (win_pos_r == sahl_pkg::WIN_IDX_W'(sahl_pkg::WINDOW_LEN - 1)) ?
                       '0 : win_pos_r + 1'b1;

  // Window storage; reset clears every tap to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sahl_pkg::WINDOW_LEN; i++) begin
        light_win_r[i] <= '0;
        temp_win_r[i]  <= '0;
      end
      win_pos_r <= '0;
    end else if (cmd.win_wr) begin
      light_win_r[win_pos_r] <= item_r.light_in;
      temp_win_r[win_pos_r]  <= item_r.temp_in;
      win_pos_r              <= win_pos_nxt;
    end
  end

  // Sum of each window.
  always_comb begin
    lsum = '0;
    tsum = '0;
    for (int i = 0; i < sahl_pkg::WINDOW_LEN; i++) begin
      lsum = lsum + sahl_pkg::LSUM_W'(light_win_r[i]);
      tsum = tsum + {{(sahl_pkg::TSUM_W - sahl_pkg::TEMP_W){temp_win_r[i][sahl_pkg::TEMP_W-1]}},
                     temp_win_r[i]};
    end
  end

  // Register the sums, the temperature as sign and magnitude.
  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      lsum_r <= lsum;
      tneg_r <= tsum[sahl_pkg::TSUM_W-1];
      tmag_r <= tsum[sahl_pkg::TSUM_W-1] ? (~tsum + 1'b1) : tsum;
    end
  end

  // Divide by the window length; truncation toward zero via the magnitude.
  assign lprod    = sahl_pkg::LPROD_W'(lsum_r) * sahl_pkg::LPROD_W'(sahl_pkg::RECIP);
  assign tprod    = sahl_pkg::TPROD_W'(tmag_r) * sahl_pkg::TPROD_W'(sahl_pkg::RECIP);
  assign tavg_mag = tprod[sahl_pkg::RECIP_SH +: sahl_pkg::TEMP_W];

  // Divider step: both lanes shift in one dividend bit per cycle.
  assign dvsr     = {1'b0, acc_cnt_r};
  assign ltrial   = {lrem_r, ldvd_r[sahl_pkg::DIV_W-1]};
  assign ttrial   = {trem_r, tdvd_r[sahl_pkg::DIV_W-1]};
  assign lge      = (ltrial >= dvsr);
  assign tge      = (ttrial >= dvsr);
  assign lrem_nxt = lge ? sahl_pkg::CNT_W'(ltrial - dvsr) : sahl_pkg::CNT_W'(ltrial);
  assign trem_nxt = tge ? sahl_pkg::CNT_W'(ttrial - dvsr) : sahl_pkg::CNT_W'(ttrial);
  assign tacc_mag = temp_acc_r[sahl_pkg::TACC_W-1] ?
                    sahl_pkg::DIV_W'(~temp_acc_r + 1'b1) : sahl_pkg::DIV_W'(temp_acc_r);

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      ldvd_r <= sahl_pkg::DIV_W'(light_acc_r);
      tdvd_r <= tacc_mag;
      dneg_r <= temp_acc_r[sahl_pkg::TACC_W-1];
      lrem_r <= '0;
      trem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      ldvd_r <= {ldvd_r[sahl_pkg::DIV_W-2:0], lge};
      tdvd_r <= {tdvd_r[sahl_pkg::DIV_W-2:0], tge};
      lrem_r <= lrem_nxt;
      trem_r <= trem_nxt;
      dcnt_r <= dcnt_r + 1'b1;
    end
  end

  // Signed temperature mean from the quotient magnitude.
  assign tq    = tdvd_r[sahl_pkg::TEMP_W-1:0];
  assign tmean = dneg_r ? (~tq + 1'b1) : tq;

  // Period accumulators: add while below the limit, clear on commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_acc_r <= '0;
      temp_acc_r  <= '0;
      acc_cnt_r   <= '0;
    end else if (cmd.commit) begin
      light_acc_r <= '0;
      temp_acc_r  <= '0;
      acc_cnt_r   <= '0;
    end else if (cmd.acc_add &&
                 (acc_cnt_r < sahl_pkg::CNT_W'(sahl_pkg::ACC_MAX))) begin
      light_acc_r <= light_acc_r + sahl_pkg::LACC_W'(res_light_r);
      temp_acc_r  <= temp_acc_r +
                     {{(sahl_pkg::TACC_W - sahl_pkg::TEMP_W){res_temp_r[sahl_pkg::TEMP_W-1]}},
                      res_temp_r};
      acc_cnt_r   <= acc_cnt_r + 1'b1;
    end
  end

  // History ring pointers.
  assign wptr_nxt = (wptr_r == sahl_pkg::HIST_IDX_W'(sahl_pkg::HIST_DEPTH - 1)) ?
                    '0 : wptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      hcnt_r <= '0;
    end else if (cmd.commit) begin
      wptr_r <= wptr_nxt;
      if (hcnt_r != sahl_pkg::HCNT_W'(sahl_pkg::HIST_DEPTH)) begin
        hcnt_r <= hcnt_r + 1'b1;
      end
    end
  end

  // Oldest-first position to ring index: the oldest entry sits at the write
  // pointer once the ring is full, and at index zero before that.
  assign rd_start = (hcnt_r == sahl_pkg::HCNT_W'(sahl_pkg::HIST_DEPTH)) ? wptr_r : '0;
  assign rd_sum   = {1'b0, rd_start} + (sahl_pkg::HIST_IDX_W + 1)'(item_r.read_pos);
  assign rd_idx   = (rd_sum >= (sahl_pkg::HIST_IDX_W + 1)'(sahl_pkg::HIST_DEPTH)) ?
                    sahl_pkg::HIST_IDX_W'(rd_sum - (sahl_pkg::HIST_IDX_W + 1)'(sahl_pkg::HIST_DEPTH)) :
                    sahl_pkg::HIST_IDX_W'(rd_sum);

  // One ring entry holds the light mean above the temperature mean.
  assign ram_wdata = {ldvd_r[sahl_pkg::LIGHT_W-1:0], tmean};

  sahl_ram #(
    .WIDTH (sahl_pkg::ENTRY_W),
    .DEPTH (sahl_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (wptr_r),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Result under construction: cleared when a request arrives.
  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      res_light_r  <= '0;
      res_temp_r   <= '0;
      res_stored_r <= 1'b0;
      res_valid_r  <= 1'b0;
    end else if (cmd.avg_ld) begin
      res_light_r <= lprod[sahl_pkg::RECIP_SH +: sahl_pkg::LIGHT_W];
      res_temp_r  <= tneg_r ? (~tavg_mag + 1'b1) : tavg_mag;
    end else if (cmd.commit) begin
      res_light_r  <= ldvd_r[sahl_pkg::LIGHT_W-1:0];
      res_temp_r   <= tmean;
      res_stored_r <= 1'b1;
    end else if (cmd.rd_ld) begin
      res_light_r <= ram_rdata[sahl_pkg::TEMP_W +: sahl_pkg::LIGHT_W];
      res_temp_r  <= ram_rdata[sahl_pkg::TEMP_W-1:0];
      res_valid_r <= 1'b1;
    end
  end

  // Output register parts the datapath from the receiver.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r.light_level <= res_light_r;
      out_data_r.temp_value  <= res_temp_r;
      out_data_r.entry_count <= hcnt_r;
      out_data_r.stored      <= res_stored_r;
      out_data_r.valid_res   <= res_valid_r;
    end
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

  // Status toward the controller.
  assign sts.req      = item_r.req_type;
  assign sts.acc_zero = (acc_cnt_r == '0);
  assign sts.read_ok  = (sahl_pkg::CMP_W'(item_r.read_pos) < sahl_pkg::CMP_W'(hcnt_r));
  assign sts.div_last = (dcnt_r == sahl_pkg::DCNT_W'(sahl_pkg::DIV_W - 1));
  assign sts.out_free = out_free;

endmodule

// ===== design/sensor_average_history_logger.sv =====
// ----------------------------------------------------------------------------
// sensor_average_history_logger
// Per-channel moving averages of light and temperature samples, period means
// and an oldest-first history ring of those means.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_stall/in_data: a sample, a period commit
//   or a history read. Each request yields exactly one result on
//   out_valid/out_stall/out_data.
//   One request is worked on at a time; in_stall is high from acceptance
//   until the result has been placed in the output register.
//   After acceptance a sample steps through DECODE, WIN, SUM, SCALE and ACC,
//   a read through DECODE, RD and RD_DATA, a commit with samples through
//   DECODE, DIV_LD, the 20-step serial divider (one quotient bit per cycle
//   for both channels at once) and COMMIT, and any other request through
//   DECODE only; each then loads the output register from OUT.
//   The output register holds a finished result while out_stall is high;
//   the block accepts the next request meanwhile and stops only when that
//   request's own result is ready and the register is still occupied.
//   Synchronous reset (rst_n low) clears the windows, accumulators, ring
//   pointers and entry count and drops out_valid; the history memory itself
//   is not cleared, and only written entries can be read back.
// ----------------------------------------------------------------------------
module sensor_average_history_logger (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  sahl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sahl_pkg::out_t out_data
);

  sahl_pkg::cmd_t cmd;
  sahl_pkg::sts_t sts;

  // Controller.
  sahl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  sahl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
